/* rtl/rational_deadline_pacer_macros.svh */
// Assertion macros shared by the pacer RTL files.
`ifndef RATIONAL_DEADLINE_PACER_MACROS_SVH
`define RATIONAL_DEADLINE_PACER_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define RDP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define RDP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/rdp_pkg.sv */
// Shared widths, constants and control structs for the rational deadline pacer.
`default_nettype none

package rdp_pkg;

    // Field and datapath widths.
    localparam int TIME_W    = 63;
    localparam int IDX_W     = 64;
    localparam int RATE_W    = 32;
    localparam int PROD_W    = 128;
    localparam int MUL_CNT_W = 5;
    localparam int DIV_CNT_W = 6;

    // Nanoseconds in one second.
    localparam logic [RATE_W-1:0] NS_PER_SEC = 32'd1000000000;

    // Saturation values.
    localparam logic [TIME_W-1:0] TIME_MAX = '1;
    localparam logic [IDX_W-1:0]  IDX_MAX  = '1;

    // Configuration register indexes.
    localparam logic CFG_RATE_NUM = 1'b0;
    localparam logic CFG_RATE_DEN = 1'b1;

    // Request types.
    localparam logic REQ_RESTART = 1'b0;
    localparam logic REQ_POLL    = 1'b1;

    // Divider start request: long mode yields 64 quotient bits, short mode 63.
    typedef struct packed {
        logic start;
        logic long_mode;
    } rdp_div_req_t;

    // Divider status: done pulses once per request, sat marks an overflowing quotient.
    typedef struct packed {
        logic done;
        logic sat;
    } rdp_div_stat_t;

endpackage

`default_nettype wire

/* rtl/rdp_mul.sv */
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle, MSB first.
`default_nettype none
`include "rational_deadline_pacer_macros.svh"

module rdp_mul (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [rdp_pkg::PROD_W-1:0]  multiplicand,
    input  logic [rdp_pkg::RATE_W-1:0]  multiplier,
    output logic                        done,
    output logic [rdp_pkg::PROD_W-1:0]  product
);
    import rdp_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [MUL_CNT_W-1:0] cnt_reg;
    logic [PROD_W-1:0]    acc_reg;
    logic [PROD_W-1:0]    a_reg;
    logic [RATE_W-1:0]    m_reg;

    logic [PROD_W-1:0]    acc_next;
    logic                 last_step;

    // Horner step: double the partial product and add the multiplicand if the bit is set.
    assign acc_next  = {acc_reg[PROD_W-2:0], 1'b0} + (m_reg[RATE_W-1] ? a_reg : '0);
    assign last_step = (cnt_reg == MUL_CNT_W'(RATE_W - 1));

    // Control: busy flag, bit counter and done pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && last_step;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + MUL_CNT_W'(1);
                if (last_step)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Datapath: operand capture and accumulation.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            a_reg   <= multiplicand;
            m_reg   <= multiplier;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            m_reg   <= {m_reg[RATE_W-2:0], 1'b0};
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

    `RDP_ASSERT_IMP(a_mul_no_restart, start, !busy_reg, "multiplier started while busy")
    `RDP_ASSERT_NXT(a_mul_done_clean, done_reg, !done_reg, "done pulse not single")
    `RDP_ASSERT_NXT(a_mul_busy_after_start, start, busy_reg, "multiplier did not start")

endmodule

`default_nettype wire

/* rtl/rdp_div.sv */
// Bit-serial restoring divider with quotient overflow detection at start.
`default_nettype none
`include "rational_deadline_pacer_macros.svh"

module rdp_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  rdp_pkg::rdp_div_req_t       req,
    input  logic [rdp_pkg::PROD_W-1:0]  numerator,
    input  logic [rdp_pkg::IDX_W-1:0]   divisor,
    output rdp_pkg::rdp_div_stat_t      stat,
    output logic [rdp_pkg::IDX_W-1:0]   quotient
);
    import rdp_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic                 sat_reg;
    logic                 long_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [IDX_W-1:0]     divisor_reg;
    logic [IDX_W-1:0]     rem_reg;
    logic [IDX_W-1:0]     low_reg;
    logic [IDX_W-1:0]     quot_reg;

    logic [IDX_W:0]       head;
    logic                 head_sat;
    logic [IDX_W:0]       trial;
    logic [IDX_W:0]       diff;
    logic                 fits;
    logic                 last_step;

    // The numerator bits above the quotient width form the starting remainder.
    // If that part already reaches the divisor, the quotient does not fit.
    assign head     = req.long_mode ? {1'b0, numerator[PROD_W-1:IDX_W]}
                                    : numerator[PROD_W-1:TIME_W];
    assign head_sat = (head >= {1'b0, divisor});

    // One restoring step: shift in the next numerator bit and try to subtract.
    assign trial     = {rem_reg, low_reg[IDX_W-1]};
    assign diff      = trial - {1'b0, divisor_reg};
    assign fits      = (trial >= {1'b0, divisor_reg});
    assign last_step = long_reg ? (cnt_reg == DIV_CNT_W'(IDX_W - 1))
                                : (cnt_reg == DIV_CNT_W'(TIME_W - 1));

    // Control: busy flag, step counter, done pulse and overflow flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            sat_reg  <= 1'b0;
            long_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                long_reg <= req.long_mode;
                cnt_reg  <= '0;
                sat_reg  <= head_sat;
                busy_reg <= !head_sat;
                done_reg <= head_sat;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + DIV_CNT_W'(1);
                if (last_step)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: remainder, numerator shifter and quotient shifter.
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            divisor_reg <= divisor;
            rem_reg     <= head[IDX_W-1:0];
            low_reg     <= req.long_mode ? numerator[IDX_W-1:0]
                                         : {numerator[TIME_W-1:0], 1'b0};
            quot_reg    <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= fits ? diff[IDX_W-1:0] : trial[IDX_W-1:0];
            low_reg  <= {low_reg[IDX_W-2:0], 1'b0};
            quot_reg <= {quot_reg[IDX_W-2:0], fits};
        end
    end

    assign stat.done = done_reg;
    assign stat.sat  = sat_reg;
    assign quotient  = quot_reg;

    `RDP_ASSERT_NXT(a_div_sat_early, req.start && head_sat, done_reg && sat_reg,
        "overflowing quotient not flagged at once")
    `RDP_ASSERT_IMP(a_div_no_restart, req.start, !busy_reg, "divider started while busy")
    `RDP_ASSERT_NXT(a_div_busy_after_start, req.start && !head_sat, busy_reg && !done_reg,
        "divider did not start its steps")

endmodule

`default_nettype wire

/* rtl/rational_deadline_pacer.sv */
// Top level of the rational deadline pacer: sequencer, state and output register.
//
//  Channel   Direction  Handshake            Payload
//  cfg       in         cfg_we               cfg_index, cfg_wdata
//  in        in         in_valid / in_ready  req_type, time_ns
//  out       out        out_valid / out_ready due, frame_index, skip_count,
//                                            target_time
//
// A restart or a poll with an invalid rate goes straight from idle to the emit state.
// A poll that is not due computes one deadline; a due poll also computes the elapsed
// count and the chosen deadline. All work runs one bit per cycle through one shared
// multiplier and one shared divider (63 or 64 quotient bits).
// One item is in work at a time; in_ready is high only while the sequencer is idle.
// The output register holds a result until it is transferred; the next item may be
// accepted and processed meanwhile, and waits only for the free output register.
// Reset clears the rate to zero, the epoch to zero and the next index to one.
`default_nettype none
`include "rational_deadline_pacer_macros.svh"

module rational_deadline_pacer (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [rdp_pkg::RATE_W-1:0]  cfg_wdata,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        req_type,
    input  logic [rdp_pkg::TIME_W-1:0]  time_ns,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        due,
    output logic [rdp_pkg::IDX_W-1:0]   frame_index,
    output logic [rdp_pkg::IDX_W-1:0]   skip_count,
    output logic [rdp_pkg::TIME_W-1:0]  target_time
);
    import rdp_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DL_START,
        S_DL_MUL1,
        S_DL_MUL2,
        S_DL_DIV,
        S_DL_ADD,
        S_DL_CMP,
        S_K_MUL,
        S_CNT_MUL,
        S_CNT_DIV,
        S_SEL,
        S_EMIT
    } state_t;

    // State and registered outputs.
    state_t              state_reg,     state_next;
    logic [RATE_W-1:0]   rate_num_reg,  rate_num_next;
    logic [RATE_W-1:0]   rate_den_reg,  rate_den_next;
    logic [TIME_W-1:0]   epoch_reg,     epoch_next;
    logic [IDX_W-1:0]    next_idx_reg,  next_idx_next;
    logic [TIME_W-1:0]   now_reg,       now_next;
    logic [IDX_W-1:0]    idx_reg,       idx_next;
    logic                second_reg,    second_next;
    logic                due_flag_reg,  due_flag_next;
    logic [TIME_W-1:0]   off_reg,       off_next;
    logic [TIME_W-1:0]   dl_reg,        dl_next;
    logic [TIME_W-1:0]   elapsed_reg,   elapsed_next;
    logic [IDX_W-1:0]    k_reg,         k_next;
    logic [IDX_W-1:0]    count_reg,     count_next;
    logic                out_valid_reg, out_valid_next;
    logic                due_reg,       due_next;
    logic [IDX_W-1:0]    index_reg,     index_next;
    logic [IDX_W-1:0]    missed_reg,    missed_next;
    logic [TIME_W-1:0]   sched_reg,     sched_next;

    // Shared arithmetic units.
    logic                mul_start;
    logic [PROD_W-1:0]   mul_a;
    logic [RATE_W-1:0]   mul_m;
    logic                mul_done;
    logic [PROD_W-1:0]   mul_product;
    rdp_div_req_t        div_req;
    logic [IDX_W-1:0]    div_divisor;
    rdp_div_stat_t       div_stat;
    logic [IDX_W-1:0]    div_quotient;

    logic [TIME_W:0]     dl_sum;
    logic                in_xfer;
    logic                emit_fire;

    rdp_mul u_mul (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (mul_start),
        .multiplicand (mul_a),
        .multiplier   (mul_m),
        .done         (mul_done),
        .product      (mul_product)
    );

    rdp_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (div_req),
        .numerator (mul_product),
        .divisor   (div_divisor),
        .stat      (div_stat),
        .quotient  (div_quotient)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign emit_fire = (state_reg == S_EMIT) && (!out_valid_reg || out_ready);

    // Deadline time is the epoch plus the offset, held at the largest time value.
    assign dl_sum = {1'b0, epoch_reg} + {1'b0, off_reg};

    // Sequencer and next-state logic.
    always_comb
    begin
        state_next     = state_reg;
        rate_num_next  = rate_num_reg;
        rate_den_next  = rate_den_reg;
        epoch_next     = epoch_reg;
        next_idx_next  = next_idx_reg;
        now_next       = now_reg;
        idx_next       = idx_reg;
        second_next    = second_reg;
        due_flag_next  = due_flag_reg;
        off_next       = off_reg;
        dl_next        = dl_reg;
        elapsed_next   = elapsed_reg;
        k_next         = k_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        due_next       = due_reg;
        index_next     = index_reg;
        missed_next    = missed_reg;
        sched_next     = sched_reg;

        mul_start         = 1'b0;
        mul_a             = '0;
        mul_m             = '0;
        div_req.start     = 1'b0;
        div_req.long_mode = 1'b0;
        div_divisor       = '0;

        // Configuration writes.
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_RATE_NUM: rate_num_next = cfg_wdata;
                CFG_RATE_DEN: rate_den_next = cfg_wdata;
                default:      rate_num_next = rate_num_reg;
            endcase
        end

        // The output register empties on a transfer.
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    now_next      = time_ns;
                    due_flag_next = 1'b0;
                    second_next   = 1'b0;
                    idx_next      = next_idx_reg;
                    if (req_type == REQ_RESTART)
                    begin
                        epoch_next    = time_ns;
                        next_idx_next = IDX_W'(1);
                        state_next    = S_EMIT;
                    end
                    else if (rate_num_reg == '0 || rate_den_reg == '0)
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_DL_START;
                    end
                end
            end

            // Deadline offset: index * den * 1e9 / num.
            S_DL_START:
            begin
                mul_start  = 1'b1;
                mul_a      = PROD_W'(idx_reg);
                mul_m      = rate_den_reg;
                state_next = S_DL_MUL1;
            end

            S_DL_MUL1:
            begin
                if (mul_done)
                begin
                    mul_start  = 1'b1;
                    mul_a      = mul_product;
                    mul_m      = NS_PER_SEC;
                    state_next = S_DL_MUL2;
                end
            end

            S_DL_MUL2:
            begin
                if (mul_done)
                begin
                    div_req.start     = 1'b1;
                    div_req.long_mode = 1'b0;
                    div_divisor       = IDX_W'(rate_num_reg);
                    state_next        = S_DL_DIV;
                end
            end

            S_DL_DIV:
            begin
                if (div_stat.done)
                begin
                    off_next   = div_stat.sat ? TIME_MAX : div_quotient[TIME_W-1:0];
                    state_next = S_DL_ADD;
                end
            end

            S_DL_ADD:
            begin
                dl_next    = dl_sum[TIME_W] ? TIME_MAX : dl_sum[TIME_W-1:0];
                state_next = S_DL_CMP;
            end

            // First pass decides whether the poll is due; second pass ends the item.
            S_DL_CMP:
            begin
                if (second_reg)
                begin
                    due_flag_next = 1'b1;
                    state_next    = S_EMIT;
                end
                else if (now_reg < dl_reg)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    elapsed_next = now_reg - epoch_reg;
                    mul_start    = 1'b1;
                    mul_a        = PROD_W'(NS_PER_SEC);
                    mul_m        = rate_den_reg;
                    state_next   = S_K_MUL;
                end
            end

            // Elapsed deadline count: elapsed * num / (1e9 * den).
            S_K_MUL:
            begin
                if (mul_done)
                begin
                    k_next     = mul_product[IDX_W-1:0];
                    mul_start  = 1'b1;
                    mul_a      = PROD_W'(elapsed_reg);
                    mul_m      = rate_num_reg;
                    state_next = S_CNT_MUL;
                end
            end

            S_CNT_MUL:
            begin
                if (mul_done)
                begin
                    div_req.start     = 1'b1;
                    div_req.long_mode = 1'b1;
                    div_divisor       = k_reg;
                    state_next        = S_CNT_DIV;
                end
            end

            S_CNT_DIV:
            begin
                if (div_stat.done)
                begin
                    count_next = div_stat.sat ? IDX_MAX : div_quotient;
                    state_next = S_SEL;
                end
            end

            // Select the later of the next index and the elapsed count.
            S_SEL:
            begin
                idx_next    = (count_reg > next_idx_reg) ? count_reg : next_idx_reg;
                second_next = 1'b1;
                state_next  = S_DL_START;
            end

            // Load the output register once it is free.
            S_EMIT:
            begin
                if (emit_fire)
                begin
                    out_valid_next = 1'b1;
                    due_next       = due_flag_reg;
                    if (due_flag_reg)
                    begin
                        index_next    = idx_reg;
                        missed_next   = idx_reg - next_idx_reg;
                        sched_next    = dl_reg;
                        next_idx_next = idx_reg + IDX_W'(1);
                    end
                    else
                    begin
                        index_next  = '0;
                        missed_next = '0;
                        sched_next  = '0;
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rate_num_reg  <= '0;
            rate_den_reg  <= '0;
            epoch_reg     <= '0;
            next_idx_reg  <= IDX_W'(1);
            now_reg       <= '0;
            idx_reg       <= '0;
            second_reg    <= 1'b0;
            due_flag_reg  <= 1'b0;
            off_reg       <= '0;
            dl_reg        <= '0;
            elapsed_reg   <= '0;
            k_reg         <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            due_reg       <= 1'b0;
            index_reg     <= '0;
            missed_reg    <= '0;
            sched_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rate_num_reg  <= rate_num_next;
            rate_den_reg  <= rate_den_next;
            epoch_reg     <= epoch_next;
            next_idx_reg  <= next_idx_next;
            now_reg       <= now_next;
            idx_reg       <= idx_next;
            second_reg    <= second_next;
            due_flag_reg  <= due_flag_next;
            off_reg       <= off_next;
            dl_reg        <= dl_next;
            elapsed_reg   <= elapsed_next;
            k_reg         <= k_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            due_reg       <= due_next;
            index_reg     <= index_next;
            missed_reg    <= missed_next;
            sched_reg     <= sched_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign due         = due_reg;
    assign frame_index = index_reg;
    assign skip_count  = missed_reg;
    assign target_time = sched_reg;

    `RDP_ASSERT_IMP(a_not_due_zero, out_valid && !due,
        frame_index == '0 && skip_count == '0 && target_time == '0,
        "result that is not due carries nonzero fields")
    `RDP_ASSERT_IMP(a_mul_done_expected, mul_done,
        state_reg == S_DL_MUL1 || state_reg == S_DL_MUL2 ||
        state_reg == S_K_MUL || state_reg == S_CNT_MUL,
        "product arrived in a state that does not wait for it")
    `RDP_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(due) && $stable(frame_index) && $stable(skip_count) &&
        $stable(target_time),
        "waiting result changed before its transfer")

endmodule

`default_nettype wire

/* bench/rational_deadline_pacer_test.sv */
// Self-checking testbench for the rational deadline pacer: random and directed traffic.
`timescale 1ns / 100ps

module rational_deadline_pacer_test;
    import rdp_pkg::*;

    localparam int QUIET_LIMIT = 12000;
    localparam int HOLD_CYCLES = 3000;
    localparam int SHOW_LIMIT  = 10;

    // One request as offered on the input channel.
    typedef struct packed {
        logic              req;
        logic [TIME_W-1:0] stamp;
    } pacer_request_t;

    // One result as seen on the output channel.
    typedef struct packed {
        logic              due;
        logic [IDX_W-1:0]  dl_index;
        logic [IDX_W-1:0]  missed;
        logic [TIME_W-1:0] sched;
    } pacer_outcome_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic                cfg_index = CFG_RATE_NUM;
    logic [RATE_W-1:0]   cfg_wdata = '0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic                req_type = REQ_RESTART;
    logic [TIME_W-1:0]   time_ns = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic                due;
    logic [IDX_W-1:0]    frame_index;
    logic [IDX_W-1:0]    skip_count;
    logic [TIME_W-1:0]   target_time;

    // Shadow copy of the rate registers and the pacing state.
    logic [RATE_W-1:0]   shadow_num = '0;
    logic [RATE_W-1:0]   shadow_den = '0;
    logic [TIME_W-1:0]   shadow_epoch = '0;
    logic [IDX_W-1:0]    shadow_next = 64'd1;

    pacer_request_t      pending_requests[$];
    pacer_outcome_t      outcome_fifo[$];
    pacer_request_t      drive_request;
    pacer_outcome_t      got_outcome;
    pacer_outcome_t      want_outcome;

    int                  sender_idle_pct = 0;
    int                  receiver_stall_pct = 0;
    int                  hold_len = 0;
    int                  hold_seq = 0;
    int                  hold_seen;
    int                  hold_left;
    int                  quiet_cycles = 0;
    int                  error_count = 0;
    int                  requests_sent = 0;
    int                  results_checked = 0;
    int                  due_results = 0;
    int                  settings_used = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    rational_deadline_pacer u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .time_ns     (time_ns),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .due         (due),
        .frame_index (frame_index),
        .skip_count  (skip_count),
        .target_time (target_time)
    );

    // Exact offset of a deadline from the epoch, saturated to 63 bits.
    function automatic logic [TIME_W-1:0] deadline_offset(input logic [IDX_W-1:0] idx);
        logic [127:0] span;
        logic [127:0] quot;
        if (shadow_num == '0)
        begin
            return '0;
        end
        span = 128'(idx) * 128'(NS_PER_SEC) * 128'(shadow_den);
        quot = span / 128'(shadow_num);
        return (quot[127:TIME_W] != '0) ? TIME_MAX : quot[TIME_W-1:0];
    endfunction

    // Absolute time of a deadline, with the epoch sum saturated as well.
    function automatic logic [TIME_W-1:0] deadline_time(input logic [IDX_W-1:0] idx);
        logic [TIME_W:0] sum;
        sum = {1'b0, shadow_epoch} + {1'b0, deadline_offset(idx)};
        return sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
    endfunction

    // Work out the result of one accepted request and advance the shadow state.
    task automatic pace_request(input logic req, input logic [TIME_W-1:0] now);
        pacer_outcome_t outcome;
        logic [127:0]   quot;
        logic [IDX_W-1:0] reached;
        logic [IDX_W-1:0] chosen;
        outcome = '0;
        if (req == REQ_RESTART)
        begin
            shadow_epoch = now;
            shadow_next  = 64'd1;
        end
        else if (shadow_num != '0 && shadow_den != '0 && now >= deadline_time(shadow_next))
        begin
            // Deadlines fully elapsed since the epoch, saturated to 64 bits.
            quot = (128'(now - shadow_epoch) * 128'(shadow_num))
                 / (128'(NS_PER_SEC) * 128'(shadow_den));
            reached = (quot[127:IDX_W] != '0) ? IDX_MAX : quot[IDX_W-1:0];
            chosen  = (reached > shadow_next) ? reached : shadow_next;
            outcome.due      = 1'b1;
            outcome.dl_index = chosen;
            outcome.missed   = chosen - shadow_next;
            outcome.sched    = deadline_time(chosen);
            shadow_next      = chosen + 64'd1;
            due_results++;
        end
        outcome_fifo.push_back(outcome);
    endtask

    // Request driver: presents queued requests and predicts each transfer.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            req_type <= REQ_RESTART;
            time_ns  <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                pace_request(req_type, time_ns);
                requests_sent++;
            end
            if (!in_valid || in_ready)
            begin
                if (pending_requests.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct)
                begin
                    drive_request = pending_requests.pop_front();
                    in_valid <= 1'b1;
                    req_type <= drive_request.req;
                    time_ns  <= drive_request.stamp;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: checks each transfer and drives the receiver's back-pressure.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_seen <= 0;
            hold_left <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got_outcome = '{due, frame_index, skip_count, target_time};
                results_checked++;
                if (outcome_fifo.size() == 0)
                begin
                    error_count++;
                    if (error_count <= SHOW_LIMIT)
                    begin
                        $display("unexpected result: due=%0b index=%0d missed=%0d sched=%0d",
                                 got_outcome.due, got_outcome.dl_index, got_outcome.missed,
                                 got_outcome.sched);
                    end
                end
                else
                begin
                    want_outcome = outcome_fifo.pop_front();
                    if (got_outcome.due !== want_outcome.due
                        || got_outcome.dl_index !== want_outcome.dl_index
                        || got_outcome.missed !== want_outcome.missed
                        || got_outcome.sched !== want_outcome.sched)
                    begin
                        error_count++;
                        if (error_count <= SHOW_LIMIT)
                        begin
                            $display("result %0d: expected due=%0b index=%0d missed=%0d sched=%0d",
                                     results_checked, want_outcome.due, want_outcome.dl_index,
                                     want_outcome.missed, want_outcome.sched);
                            $display("    got due=%0b index=%0d missed=%0d sched=%0d",
                                     got_outcome.due, got_outcome.dl_index, got_outcome.missed,
                                     got_outcome.sched);
                        end
                    end
                end
            end
            // A new hold-off request starts a long stretch with ready low.
            if (hold_seq != hold_seen)
            begin
                hold_seen <= hold_seq;
                hold_left <= hold_len;
                out_ready <= 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
            end
        end
    end

    // Watchdog: ends the run if no transfer happens for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("watchdog: no transfer for %0d cycles", quiet_cycles);
                $display("[rational_deadline_pacer] ERROR");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    function automatic logic [TIME_W-1:0] rand_stamp();
        logic [63:0] wide;
        wide = {$urandom, $urandom};
        return wide[TIME_W-1:0];
    endfunction

    task automatic push_request(input logic req, input logic [TIME_W-1:0] stamp);
        pending_requests.push_back('{req, stamp});
    endtask

    // Waits until every queued request has been transferred and answered.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_requests.size() != 0 || in_valid || outcome_fifo.size() != 0);
        repeat (8) @(posedge clk);
    endtask

    // Writes both rate registers and selects the idling pattern for the next phase.
    task automatic set_phase(input logic [RATE_W-1:0] num, input logic [RATE_W-1:0] den,
                             input int send_pct, input int recv_pct);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_RATE_NUM;
        cfg_wdata <= num;
        @(posedge clk);
        cfg_index <= CFG_RATE_DEN;
        cfg_wdata <= den;
        @(posedge clk);
        cfg_we    <= 1'b0;
        shadow_num = num;
        shadow_den = den;
        @(negedge clk);
        sender_idle_pct    = send_pct;
        receiver_stall_pct = recv_pct;
        settings_used++;
    endtask

    // Restart followed by polls placed around upcoming deadlines, with some noise mixed in.
    task automatic add_traffic(input int count);
        int               left;
        int               polls;
        int               pick;
        logic [63:0]      wide;
        logic [TIME_W-1:0] base;
        logic [TIME_W-1:0] span;
        logic [TIME_W-1:0] jit;
        logic [IDX_W-1:0] k;
        logic [TIME_W+1:0] t;
        left = count;
        while (left > 0)
        begin
            case ($urandom_range(0, 3))
                0: base = TIME_W'($urandom_range(0, 1000000));
                1:
                begin
                    wide = {$urandom, $urandom};
                    base = TIME_W'(wide >> $urandom_range(1, 40));
                end
                2: base = TIME_MAX - TIME_W'($urandom_range(0, 1000));
                default: base = rand_stamp();
            endcase
            push_request(REQ_RESTART, base);
            left--;
            k     = 64'd1;
            span  = deadline_offset(64'd1);
            jit   = (span < 63'h1_0000_0000) ? TIME_W'($urandom_range(0, span[31:0]))
                                             : TIME_W'($urandom);
            polls = $urandom_range(1, 12);
            for (int p = 0; p < polls && left > 0; p++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 8)
                begin
                    push_request(REQ_POLL, rand_stamp());
                end
                else if (pick < 11)
                begin
                    // Broken sequence: a stray restart the later polls do not follow.
                    push_request(REQ_RESTART, rand_stamp());
                end
                else
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 55)
                        k = k + 64'd1;
                    else if (pick < 88 && pick >= 70)
                        k = k + 64'($urandom_range(2, 8));
                    else if (pick < 95 && pick >= 88)
                        k = k + 64'($urandom_range(9, 1000));
                    else if (pick >= 95)
                        k = k + {$urandom, $urandom};
                    t = {2'b0, base} + {2'b0, deadline_offset(k)};
                    case ($urandom_range(0, 7))
                        0, 1, 2: t = t;
                        3: t = (t != '0) ? t - (TIME_W+2)'(1) : t;
                        4: t = t + (TIME_W+2)'(1);
                        5: t = (t >= {2'b0, jit}) ? t - {2'b0, jit} : '0;
                        default: t = t + {2'b0, jit};
                    endcase
                    push_request(REQ_POLL, (t > {2'b0, TIME_MAX}) ? TIME_MAX : t[TIME_W-1:0]);
                end
                left--;
            end
        end
    endtask

    // Stimulus sequence: directed corner cases first, then random phases.
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Rate registers still at their reset value: nothing is ever due.
        push_request(REQ_POLL, '0);
        push_request(REQ_POLL, TIME_MAX);
        push_request(REQ_RESTART, 63'd12345);
        push_request(REQ_POLL, TIME_MAX);
        push_request(REQ_RESTART, '0);
        wait_idle();

        // Video rate: boundaries around deadlines, skipped deadlines, time before epoch.
        set_phase(32'd30000, 32'd1001, 0, 0);
        push_request(REQ_POLL, '0);
        push_request(REQ_RESTART, 63'd1000);
        push_request(REQ_POLL, 63'd999);
        push_request(REQ_POLL, 63'd1000 + deadline_offset(64'd1) - 63'd1);
        push_request(REQ_POLL, 63'd1000 + deadline_offset(64'd1));
        push_request(REQ_POLL, 63'd1000 + deadline_offset(64'd2));
        push_request(REQ_POLL, 63'd1000 + deadline_offset(64'd12) + 63'd5);
        push_request(REQ_POLL, 63'd1000 + deadline_offset(64'd12));
        push_request(REQ_POLL, TIME_MAX);
        // Epoch near the top of the time range: the scheduled time saturates.
        push_request(REQ_RESTART, TIME_MAX);
        push_request(REQ_POLL, TIME_MAX);
        add_traffic(200);
        wait_idle();

        // Fastest rate: the deadline count saturates and the next index wraps to zero.
        set_phase(32'hFFFF_FFFF, 32'd1, 75, 0);
        push_request(REQ_RESTART, '0);
        push_request(REQ_POLL, '0);
        push_request(REQ_POLL, TIME_MAX);
        push_request(REQ_POLL, '0);
        push_request(REQ_POLL, 63'd1);
        add_traffic(150);
        wait_idle();

        // Slowest rate: the deadline offset saturates from index three on.
        set_phase(32'd1, 32'hFFFF_FFFF, 0, 75);
        push_request(REQ_RESTART, 63'd5);
        push_request(REQ_POLL, 63'd5 + deadline_offset(64'd1));
        push_request(REQ_POLL, TIME_MAX);
        push_request(REQ_POLL, TIME_MAX);
        add_traffic(120);
        wait_idle();

        // Invalid rates: a zero numerator, then a zero denominator.
        set_phase(32'd0, 32'd1, 8, 8);
        add_traffic(60);
        wait_idle();
        set_phase(32'd1, 32'd0, 0, 0);
        add_traffic(60);
        wait_idle();

        // Long receiver hold-off while the sender keeps offering requests.
        set_phase(32'd60, 32'd1, 0, 0);
        add_traffic(200);
        @(negedge clk);
        hold_len = HOLD_CYCLES;
        hold_seq++;
        wait_idle();

        set_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8, 8);
        add_traffic(150);
        wait_idle();
        set_phase(32'd24000, 32'd1001, 75, 0);
        add_traffic(150);
        wait_idle();
        set_phase(RATE_W'($urandom_range(1, 100000)), RATE_W'($urandom_range(1, 5000)), 0, 75);
        add_traffic(200);
        wait_idle();
        set_phase($urandom, $urandom, 8, 8);
        add_traffic(150);
        wait_idle();
        set_phase(32'd25, 32'd1, 0, 0);
        add_traffic(160);
        wait_idle();

        // Allow a late stray result to show up before closing.
        repeat (450) @(posedge clk);
        if (outcome_fifo.size() != 0)
        begin
            error_count++;
            $display("%0d results never arrived", outcome_fifo.size());
        end
        $display("summary: %0d requests, %0d results checked, %0d due, %0d rate settings",
                 requests_sent, results_checked, due_results, settings_used);
        $display("summary: invalid and extreme rates, saturation, index wrap, stalls, hold-off");
        if (error_count == 0)
        begin
            $display("[rational_deadline_pacer] OK");
        end
        else
        begin
            $display("%0d mismatches", error_count);
            $display("[rational_deadline_pacer] ERROR");
        end
        $finish;
    end

endmodule
